// ===== sv/frm_pkg.sv =====
// Shared types and constants for the frame packet reassembler.
// No dependencies; imported by every module of the block.
package frm_pkg;

    localparam int PAYLOAD_BYTES_DEF   = 1400;
    localparam int FRAME_ADDR_BITS_DEF = 24;

    localparam int ADDR_W     = 24;  // width of the write_address field
    localparam int PPF_W      = 16;
    localparam int LEN_W      = 11;
    localparam int FB_W       = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 3;

    localparam logic [POS_W-1:0] HDR_LEN = 3'd6;

    localparam logic [7:0] HDR_CHAR_F     = 8'h46;
    localparam logic [7:0] HDR_CHAR_R     = 8'h52;
    localparam logic [7:0] HDR_CHAR_M     = 8'h4D;
    localparam logic [7:0] HDR_CHAR_COLON = 8'h3A;

    localparam logic [PPF_W-1:0] PPF_RST         = 16'd1;
    localparam logic [LEN_W-1:0] FINAL_LEN_RST   = 11'd1400;
    localparam logic [FB_W-1:0]  FRAME_BYTES_RST = 24'd1400;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_BAD_HDR = 2'd2,
        KIND_OVERRUN = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACKETS_PER_FRAME   = 2'd0,
        CFG_FINAL_PACKET_LENGTH = 2'd1,
        CFG_FRAME_BYTES         = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       datagram_start;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic              frame_end;
    } out_item_t;

    typedef struct packed {
        logic [PPF_W-1:0] packets_per_frame;
        logic [LEN_W-1:0] final_packet_length;
        logic [FB_W-1:0]  frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } core_res_t;

endpackage

// ===== sv/frm_in_stage.sv =====
// Input register of the reassembler: holds one received byte until the core takes it.
// Depends on frm_pkg.
module frm_in_stage
    import frm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    assign in_ready   = !vld_reg || take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/frm_core.sv =====
// Header parse, packet placement and payload address tracking, one byte per cycle while fire is high.
// Depends on frm_pkg.
module frm_core
    import frm_pkg::*;
#(
    parameter int PAYLOAD_BYTES   = PAYLOAD_BYTES_DEF,
    parameter int FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output core_res_t res
);

    localparam int PB_W   = $clog2(PAYLOAD_BYTES + 1);
    localparam int PROD_W = PPF_W + PB_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMP_W  = (SUM_W > FB_W) ? SUM_W : FB_W;

    localparam logic [PROD_W-1:0] PB_P = PROD_W'(PAYLOAD_BYTES);
    localparam logic [LEN_W-1:0]  PB_L = LEN_W'(PAYLOAD_BYTES);

    logic [POS_W-1:0]           pos_reg, pos_next, pos_cur;
    logic                       hok_reg, hok_next;
    logic                       acc_reg, acc_next, acc_cur;
    logic [LEN_W-1:0]           left_reg, left_next, left_cur;
    logic [7:0]                 pn_hi_reg, pn_hi_next;
    logic [PROD_W-1:0]          part_reg, part_next;
    logic [FRAME_ADDR_BITS-1:0] addr_reg, addr_next;

    logic [PPF_W-1:0]  id;
    logic              is_last;
    logic [LEN_W-1:0]  len;
    logic [PROD_W-1:0] ofst;
    logic [CMP_W-1:0]  need;
    logic              over;

    assign pos_cur  = item.datagram_start ? '0 : pos_reg;
    assign acc_cur  = item.datagram_start ? 1'b0 : acc_reg;
    assign left_cur = item.datagram_start ? '0 : left_reg;

    // part_reg already holds hi*256*P - P, so adding lo*P gives (id-1)*P for id >= 1
    assign id      = {pn_hi_reg, item.data_byte};
    assign is_last = (id == cfg.packets_per_frame);
    assign len     = is_last ? cfg.final_packet_length : PB_L;
    assign ofst    = part_reg + PROD_W'(item.data_byte) * PB_P;
    assign need    = CMP_W'(ofst) + CMP_W'(len);
    assign over    = (need > CMP_W'(cfg.frame_bytes));

    always_comb
    begin
        pos_next   = pos_cur;
        hok_next   = hok_reg;
        acc_next   = acc_cur;
        left_next  = left_cur;
        pn_hi_next = pn_hi_reg;
        part_next  = part_reg;
        addr_next  = addr_reg;
        res        = '0;

        if (pos_cur == HDR_LEN)
        begin
            if (acc_cur && (left_cur != '0))
            begin
                res.valid              = 1'b1;
                res.item.kind          = KIND_WRITE;
                res.item.write_address = ADDR_W'(addr_reg);
                res.item.write_data    = item.data_byte;
                addr_next              = addr_reg + 1'b1;
                left_next              = left_cur - 1'b1;
                acc_next               = (left_cur != LEN_W'(1));
            end
        end
        else
        begin
            unique case (pos_cur)
                3'd0: hok_next = (item.data_byte == HDR_CHAR_F);
                3'd1: hok_next = hok_reg && (item.data_byte == HDR_CHAR_R);
                3'd2: hok_next = hok_reg && (item.data_byte == HDR_CHAR_M);
                3'd3: hok_next = hok_reg && (item.data_byte == HDR_CHAR_COLON);
                3'd4:
                begin
                    pn_hi_next = item.data_byte;
                    part_next  = PROD_W'({item.data_byte, 8'h00}) * PB_P - PB_P;
                end
                default: ;
            endcase
            pos_next = pos_cur + 1'b1;

            if (pos_cur == HDR_LEN - 1'b1)
            begin
                res.valid = 1'b1;
                priority if (!hok_reg)
                begin
                    res.item.kind = KIND_BAD_HDR;
                end
                else if ((id == '0) || over)
                begin
                    res.item.kind      = KIND_OVERRUN;
                    res.item.frame_end = is_last;
                end
                else
                begin
                    res.item.kind      = KIND_ACCEPT;
                    res.item.frame_end = is_last;
                    addr_next          = FRAME_ADDR_BITS'(ofst);
                    left_next          = len;
                    acc_next           = (len != '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hok_reg  <= 1'b0;
            acc_reg  <= 1'b0;
            left_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg  <= pos_next;
            hok_reg  <= hok_next;
            acc_reg  <= acc_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pn_hi_reg <= pn_hi_next;
            part_reg  <= part_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

// ===== sv/frm_out_stage.sv =====
// Result register of the reassembler: holds one result until the consumer takes it.
// Depends on frm_pkg.
module frm_out_stage
    import frm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t res_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      vld_reg;
    logic      vld_next;
    out_item_t item_reg;

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res_item;
        end
    end

endmodule

// ===== sv/frame_packet_reassembler.sv =====
// Top level of the frame packet reassembler: config registers and stage wiring.
// Depends on frm_pkg, frm_in_stage, frm_core, frm_out_stage.
//
//  port group   | dir | handshake              | carries
//  -------------+-----+------------------------+----------------------------------
//  in_*         | in  | in_valid / in_ready    | in_item_t: data_byte, datagram_start
//  out_*        | out | out_valid / out_ready  | out_item_t: kind, address, data, end
//  cfg_*        | in  | cfg_write_en (no wait) | register index and write data
//
// One byte per cycle sustained while out_ready is held high.
// Each byte passes input register -> header/placement logic -> result register; the
// placement offset is built from a partial product taken on the high id byte.
// Reset clears all control state; config registers return to their defaults.
// A stalled output holds the core while a result waits; in_ready drops once the
// input register is also full.
module frame_packet_reassembler
    import frm_pkg::*;
#(
    parameter int PAYLOAD_BYTES   = PAYLOAD_BYTES_DEF,
    parameter int FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_write_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      item_valid;
    in_item_t  item;
    logic      fire;
    core_res_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PACKETS_PER_FRAME:
                    cfg_next.packets_per_frame = cfg_write_data[PPF_W-1:0];
                CFG_FINAL_PACKET_LENGTH:
                    cfg_next.final_packet_length = cfg_write_data[LEN_W-1:0];
                CFG_FRAME_BYTES:
                    cfg_next.frame_bytes = cfg_write_data[FB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packets_per_frame   <= PPF_RST;
            cfg_reg.final_packet_length <= FINAL_LEN_RST;
            cfg_reg.frame_bytes         <= FRAME_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // core advances when a byte is held and the result slot is free or draining
    assign fire = item_valid && (!out_valid || out_ready);

    frm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    frm_core #(
        .PAYLOAD_BYTES   (PAYLOAD_BYTES),
        .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    frm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res.valid),
        .res_item  (res.item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.valid) |=> out_valid)
        else $error("core result did not reach the result register");

    a_status_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.kind != KIND_WRITE))
            |-> ((out_item.write_address == '0) && (out_item.write_data == '0)))
        else $error("status transaction carries write address or data");

    a_frame_end_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_item.kind == KIND_WRITE) || (out_item.kind == KIND_BAD_HDR)))
            |-> !out_item.frame_end)
        else $error("frame_end set on a write or invalid header transaction");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !fire)
        else $error("core advanced while the result register was stalled");

endmodule

// ===== tb/tb_frame_packet_reassembler.sv =====
// Testbench for frame_packet_reassembler: drives datagram bytes, predicts every result.
// Depends on frm_pkg and the frame_packet_reassembler RTL; self-checking, no files.
`timescale 1ns / 100ps

module tb_frame_packet_reassembler;
    import frm_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either channel
    localparam int DRAIN_CYCLES = 8;     // pipeline is two deep; leave margin
    localparam int PKT_BYTES    = PAYLOAD_BYTES_DEF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_write_data = '0;

    frame_packet_reassembler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data)
    );

    always #1 clk = ~clk;

    // shadow registers and reassembly state
    logic [PPF_W-1:0]  cfg_ppf = PPF_RST;
    logic [LEN_W-1:0]  cfg_fpl = FINAL_LEN_RST;
    logic [FB_W-1:0]   cfg_fb  = FRAME_BYTES_RST;
    int                hdr_pos = 0;
    logic              hdr_good = 1'b0;
    logic [15:0]       pkt_id = '0;
    logic [ADDR_W-1:0] wr_addr = '0;
    logic [LEN_W-1:0]  wr_left = '0;
    logic              writing = 1'b0;

    out_item_t expected_out[$];

    int err_count      = 0;
    int bytes_sent     = 0;
    int datagrams_sent = 0;
    int config_sets    = 0;
    int kind_seen[4]   = '{0, 0, 0, 0};
    int frame_ends     = 0;
    int burst_left     = 0;
    logic gapless      = 1'b0;
    int idle_cycles    = 0;
    int stall_mode     = 0;
    int stall_len      = 0;

    function automatic out_item_t make_result(kind_t k, logic [ADDR_W-1:0] a, logic [7:0] d,
                                              logic fe);
        out_item_t r;
        r.kind          = k;
        r.write_address = a;
        r.write_data    = d;
        r.frame_end     = fe;
        return r;
    endfunction

    task automatic reassemble_byte(input in_item_t it);
        logic [7:0]       b;
        logic             last;
        logic [LEN_W-1:0] len;
        longint           ofst;
        b = it.data_byte;
        if (it.datagram_start)
        begin
            hdr_pos = 0;
            writing = 1'b0;
            wr_left = '0;
        end
        if (hdr_pos >= 6)
        begin
            if (writing && wr_left != 0)
            begin
                expected_out.push_back(make_result(KIND_WRITE, wr_addr, b, 1'b0));
                wr_addr = wr_addr + 1'b1;
                wr_left = wr_left - 1'b1;
                if (wr_left == 0)
                    writing = 1'b0;
            end
            return;
        end
        case (hdr_pos)
            0: hdr_good = (b == HDR_CHAR_F);
            1: hdr_good = hdr_good && (b == HDR_CHAR_R);
            2: hdr_good = hdr_good && (b == HDR_CHAR_M);
            3: hdr_good = hdr_good && (b == HDR_CHAR_COLON);
            4: pkt_id = {b, 8'h00};
            default: pkt_id = {pkt_id[15:8], b};
        endcase
        hdr_pos++;
        if (hdr_pos < 6)
            return;
        if (!hdr_good)
        begin
            expected_out.push_back(make_result(KIND_BAD_HDR, '0, '0, 1'b0));
            return;
        end
        last = (pkt_id == cfg_ppf);
        len  = last ? cfg_fpl : LEN_W'(PKT_BYTES);
        if (pkt_id == 0)
        begin
            expected_out.push_back(make_result(KIND_OVERRUN, '0, '0, last));
            return;
        end
        ofst = (longint'(pkt_id) - 1) * PKT_BYTES;
        if (ofst + longint'(len) > longint'(cfg_fb))
        begin
            expected_out.push_back(make_result(KIND_OVERRUN, '0, '0, last));
            return;
        end
        wr_addr = ofst[ADDR_W-1:0];
        wr_left = len;
        writing = (len != 0);
        expected_out.push_back(make_result(KIND_ACCEPT, '0, '0, last));
    endtask

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            reassemble_byte(in_item);

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            kind_seen[int'(out_item.kind)]++;
            if (out_item.kind != KIND_WRITE && out_item.frame_end)
                frame_ends++;
            if (expected_out.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: kind=%0d addr=%0h data=%0h end=%0d",
                             out_item.kind, out_item.write_address, out_item.write_data,
                             out_item.frame_end);
            end
            else
            begin
                want = expected_out.pop_front();
                if (want.kind != out_item.kind || want.write_address != out_item.write_address
                    || want.write_data != out_item.write_data
                    || want.frame_end != out_item.frame_end)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: exp kind=%0d addr=%0h data=%0h end=%0d,",
                                  " got kind=%0d addr=%0h data=%0h end=%0d"},
                                 want.kind, want.write_address, want.write_data,
                                 want.frame_end, out_item.kind, out_item.write_address,
                                 out_item.write_data, out_item.frame_end);
                end
            end
        end
    end

    // receiver backpressure: switches at random between four ready patterns
    always @(posedge clk)
    begin
        if (stall_len == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_len  = $urandom_range(8, 64);
        end
        stall_len--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (stall_len % 4 == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_out.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        in_item_t it;
        int       gap;
        if (burst_left == 0)
        begin
            gap = gapless ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        it.data_byte      = b;
        it.datagram_start = s;
        in_item  <= it;
        in_valid <= 1'b1;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // header of hdr_len bytes (one bad byte at bad_pos if >= 0), then payload if complete
    task automatic send_datagram(input logic [15:0] id, input logic marked, input int bad_pos,
                                 input int hdr_len, input int n_payload);
        logic [7:0] hdr [6];
        logic [7:0] v;
        hdr[0] = HDR_CHAR_F;
        hdr[1] = HDR_CHAR_R;
        hdr[2] = HDR_CHAR_M;
        hdr[3] = HDR_CHAR_COLON;
        hdr[4] = id[15:8];
        hdr[5] = id[7:0];
        if (bad_pos >= 0)
        begin
            v = 8'($urandom_range(0, 255));
            if (v == hdr[bad_pos])
                v = v ^ 8'h01;
            hdr[bad_pos] = v;
        end
        datagrams_sent++;
        for (int i = 0; i < hdr_len; i++)
            send_byte(hdr[i], marked && i == 0);
        if (hdr_len == 6)
            for (int i = 0; i < n_payload; i++)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // lower valid and wait out every expected result plus the pipeline depth
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_out.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [PPF_W-1:0] ppf_v, input logic [LEN_W-1:0] fpl_v,
                                input logic [FB_W-1:0] fb_v);
        cfg_write_en   <= 1'b1;
        cfg_index      <= CFG_PACKETS_PER_FRAME;
        cfg_write_data <= CFG_DATA_W'(ppf_v);
        @(posedge clk);
        cfg_index      <= CFG_FINAL_PACKET_LENGTH;
        cfg_write_data <= CFG_DATA_W'(fpl_v);
        @(posedge clk);
        cfg_index      <= CFG_FRAME_BYTES;
        cfg_write_data <= CFG_DATA_W'(fb_v);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cfg_ppf = ppf_v;
        cfg_fpl = fpl_v;
        cfg_fb  = fb_v;
        config_sets++;
    endtask

    // bytes before any start marker belong to a datagram opened by reset
    task automatic test_no_start_marker();
        send_datagram(16'd1, 1'b0, -1, 6, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_header_errors();
        send_datagram(16'd1, 1'b1, 2, 6, 1);   // bad header, payload ignored
        send_datagram(16'd1, 1'b1, -1, 3, 0);  // cut short, no status
        send_datagram(16'd0, 1'b1, -1, 6, 1);  // id zero always overruns
    endtask

    task automatic test_last_packet_limits();
        settle();
        write_config(16'd3, 11'd2, 24'd2802);
        send_datagram(16'd3, 1'b1, -1, 6, 4);   // exactly fills frame, extra bytes dropped
        send_datagram(16'd2, 1'b1, -1, 6, 1);   // short payload
        send_datagram(16'd4, 1'b1, -1, 6, 0);   // past frame end
        send_datagram(16'hFFFF, 1'b1, -1, 6, 0);
    endtask

    task automatic test_config_extremes();
        settle();
        write_config(16'd1, 11'd0, 24'hFFFFFF);  // zero-length last packet
        send_datagram(16'd1, 1'b1, -1, 6, 1);
        settle();
        write_config(16'd0, 11'd1400, 24'd1);
        send_datagram(16'd0, 1'b1, -1, 6, 0);   // overrun with frame end
        send_datagram(16'd1, 1'b1, -1, 6, 0);
        settle();
        write_config(16'hFFFF, 11'h7FF, 24'hFFFFFF);
        send_datagram(16'hFFFF, 1'b1, -1, 6, 0);
        send_datagram(16'd11983, 1'b1, -1, 6, 2); // highest packet that fits
        send_datagram(16'd11984, 1'b1, -1, 6, 0);
    endtask

    // long last packet that fills the frame, two bytes past its length ignored
    task automatic test_full_packet();
        settle();
        write_config(16'd2, 11'd300, 24'd1700);
        gapless = 1'b1;
        send_datagram(16'd2, 1'b1, -1, 6, 302);
        gapless = 1'b0;
    endtask

    task automatic random_datagram();
        int          pick;
        int          sel;
        int          n;
        logic [15:0] id;
        pick = $urandom_range(0, 19);
        sel  = $urandom_range(0, 9);
        case (sel)
            0: id = 16'd0;
            1: id = 16'($urandom);
            2, 3: id = cfg_ppf;
            default: id = 16'($urandom_range(1, int'(cfg_ppf) + 1));
        endcase
        if (pick < 15)
        begin
            n = (id == cfg_ppf) ? $urandom_range(0, int'(cfg_fpl) + 3) : $urandom_range(0, 10);
            send_datagram(id, 1'b1, -1, 6, n);
        end
        else if (pick < 17)
            send_datagram(id, 1'b1, $urandom_range(0, 3), 6, $urandom_range(0, 4));
        else if (pick < 19)
            send_datagram(id, 1'b1, -1, $urandom_range(1, 5), 0);
        else
        begin
            n = $urandom_range(1, 12);
            datagrams_sent++;
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 5) == 0);
        end
        if ($urandom_range(0, 29) == 0)
            settle();
    endtask

    task automatic test_random_traffic();
        logic [PPF_W-1:0] ppf_v;
        logic [LEN_W-1:0] fpl_v;
        int               fb_v;
        int               stop_at;
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            ppf_v = 16'($urandom_range(1, 6));
            fpl_v = 11'($urandom_range(0, 16));
            fb_v  = (int'(ppf_v) - 1) * PKT_BYTES + int'(fpl_v) + int'($urandom_range(0, 2)) - 1;
            if (ph == 5)
            begin
                ppf_v = 16'($urandom);
                fb_v  = int'(24'hFFFFFF);
            end
            if (fb_v < 1)
                fb_v = 1;
            write_config(ppf_v, fpl_v, fb_v[FB_W-1:0]);
            gapless = (ph == 2);
            stop_at = bytes_sent + 70;
            while (bytes_sent < stop_at)
                random_datagram();
        end
        gapless = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_start_marker();
        test_header_errors();
        test_last_packet_limits();
        test_config_extremes();
        test_full_packet();
        test_random_traffic();
        settle();
        $display("sent %0d bytes in %0d datagrams over %0d register settings",
                 bytes_sent, datagrams_sent, config_sets);
        $display("got %0d writes, %0d accepted, %0d bad header, %0d overrun, %0d frame ends",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], frame_ends);
        if (err_count == 0 && expected_out.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", err_count,
                     expected_out.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
